// ===== design/pia_pkg.sv =====
// Shared types and constants for the two-port parallel interface adapter.
// Holds the command and response word layouts, the per-port register set and operation codes.
// No dependencies.
`default_nettype none

package pia_pkg;

	// Operation codes carried in the func field
	localparam logic [1:0] FUNC_BUS_WRITE  = 2'b00;
	localparam logic [1:0] FUNC_BUS_READ   = 2'b01;
	localparam logic [1:0] FUNC_DEV_INPUT  = 2'b10;
	localparam logic [1:0] FUNC_SET_IRQ    = 2'b11;

	// Control byte bit positions
	localparam int CTRL_DATA_ACCESS = 2;
	localparam int CTRL_C2_OUTPUT   = 5;
	localparam int CTRL_FLAG_TWO    = 6;
	localparam int CTRL_FLAG_ONE    = 7;

	// Interrupt line select
	localparam logic IRQ_LINE_ONE = 1'b0;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] reg_select;
		logic [7:0] data_in;
		logic       port_sel;
		logic       irq_line;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       dev_write_valid;
		logic       dev_write_port;
		logic [7:0] dev_write_data;
	} rsp_word_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] dir;
		logic [7:0] ctrl;
	} port_regs_t;

endpackage

`default_nettype wire

// ===== design/pia_exec.sv =====
// Combinational execute logic for one adapter operation.
// Computes next port register values and the response word; uses pia_pkg.
`default_nettype none

module pia_exec (
	input  var pia_pkg::cmd_word_t  cmd,
	input  var pia_pkg::port_regs_t port_a,
	input  var pia_pkg::port_regs_t port_b,
	output pia_pkg::port_regs_t     port_a_nxt,
	output pia_pkg::port_regs_t     port_b_nxt,
	output pia_pkg::rsp_word_t      rsp
);

	logic                which;
	pia_pkg::port_regs_t cur;
	pia_pkg::port_regs_t upd;

	// Pick the port: address bit for bus accesses, port_sel for device events
	always_comb begin
		if (cmd.func == pia_pkg::FUNC_BUS_WRITE || cmd.func == pia_pkg::FUNC_BUS_READ) begin
			which = cmd.reg_select[1];
		end else begin
			which = cmd.port_sel;
		end
		cur = which ? port_b : port_a;
	end

	// Apply the operation to the selected port
	always_comb begin
		upd = cur;
		rsp = '0;
		unique case (cmd.func)
			pia_pkg::FUNC_BUS_WRITE: begin
				if (cmd.reg_select[0]) begin
					upd.ctrl = cmd.data_in;
				end else if (cur.ctrl[pia_pkg::CTRL_DATA_ACCESS]) begin
					upd.data = (cmd.data_in & cur.dir) | (cur.data & ~cur.dir);
					rsp.dev_write_valid = 1'b1;
					rsp.dev_write_port  = which;
					rsp.dev_write_data  = cmd.data_in;
				end else begin
					upd.dir = cmd.data_in;
				end
			end
			pia_pkg::FUNC_BUS_READ: begin
				if (cmd.reg_select[0]) begin
					rsp.read_data = cur.ctrl;
				end else if (cur.ctrl[pia_pkg::CTRL_DATA_ACCESS]) begin
					// reading port data acknowledges both flags
					upd.ctrl[pia_pkg::CTRL_FLAG_ONE] = 1'b0;
					upd.ctrl[pia_pkg::CTRL_FLAG_TWO] = 1'b0;
					rsp.read_data = cur.data;
				end else begin
					rsp.read_data = cur.dir;
				end
			end
			pia_pkg::FUNC_DEV_INPUT: begin
				upd.data = (cmd.data_in & ~cur.dir) | (cur.data & cur.dir);
			end
			pia_pkg::FUNC_SET_IRQ: begin
				if (cmd.irq_line == pia_pkg::IRQ_LINE_ONE) begin
					upd.ctrl[pia_pkg::CTRL_FLAG_ONE] = 1'b1;
				end else if (!cur.ctrl[pia_pkg::CTRL_C2_OUTPUT]) begin
					upd.ctrl[pia_pkg::CTRL_FLAG_TWO] = 1'b1;
				end
			end
			default: begin
				upd = cur;
			end
		endcase
	end

	// Route the updated set back to its port
	assign port_a_nxt = which ? port_a : upd;
	assign port_b_nxt = which ? upd : port_b;

endmodule

`default_nettype wire

// ===== design/pia_register_model_unit.sv =====
// Two-port parallel interface adapter register model: top level.
// Command register, port register file and response register around pia_exec.
// Uses pia_pkg and pia_exec.
//
// Usage:
//   The cmd channel carries one operation word (bus write, bus read, device input
//   or set interrupt flag). A word is taken at a clock edge with cmd_valid high and
//   cmd_stall low. Every command yields exactly one rsp word, taken at an edge with
//   rsp_valid high and rsp_stall low.
//   Path: the accepting edge loads the command register; the command then executes
//   into the response register and port registers together once the response
//   register is free or draining, and the word can then be taken from rsp.
//   Throughput: one command per cycle unless a response is stalled; the port
//   register read-modify-write lets consecutive commands see each other's effects.
//   Stall: when rsp_stall holds a waiting response, the command register keeps its
//   word and cmd_stall rises once that register is full; one command is buffered.
//   Reset: arst_n low clears all port data, direction and control bytes to zero
//   and empties both pipeline registers.
`default_nettype none

module pia_register_model_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_stall,
	input  var pia_pkg::cmd_word_t cmd,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output pia_pkg::rsp_word_t rsp
);

	logic                valid_s1;
	pia_pkg::cmd_word_t  cmd_s1;
	logic                fire_s1;
	pia_pkg::port_regs_t port_a_q;
	pia_pkg::port_regs_t port_b_q;
	pia_pkg::port_regs_t port_a_nxt;
	pia_pkg::port_regs_t port_b_nxt;
	pia_pkg::rsp_word_t  rsp_nxt;
	pia_pkg::rsp_word_t  rsp_q;
	logic                rsp_valid_q;

	// Advance the command stage whenever the response register is free or draining
	assign fire_s1   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !fire_s1;

	// Hold the command word until it executes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	pia_exec u_exec (
		.cmd        (cmd_s1),
		.port_a     (port_a_q),
		.port_b     (port_b_q),
		.port_a_nxt (port_a_nxt),
		.port_b_nxt (port_b_nxt),
		.rsp        (rsp_nxt)
	);

	// Commit port registers when a command executes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_q <= '0;
			port_b_q <= '0;
		end else if (fire_s1) begin
			port_a_q <= port_a_nxt;
			port_b_q <= port_b_nxt;
		end
	end

	// Response register: load on execute, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An executing command always produces a response next cycle
	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> rsp_valid)
		else $error("executed command produced no response");

	// Back-pressure only with a full command register and a blocked response
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("cmd_stall without a blocked response");

	// A device write strobe never coincides with read data
	a_write_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.dev_write_valid) |-> (rsp.read_data == 8'h00))
		else $error("device write response carries read data");

	// Without a strobe, the device write fields stay zero
	a_idle_strobe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.dev_write_valid) |->
			(rsp.dev_write_port == 1'b0 && rsp.dev_write_data == 8'h00))
		else $error("device write fields set without strobe");

endmodule

`default_nettype wire
